// ===== src/reb_pkg.sv =====
// shared types and constants for the rotary encoder / button scanner
// no dependencies; used by reb_core and rotary_encoder_button_scanner
`timescale 1ns / 1ps

package reb_pkg;

  localparam int unsigned THR_W = 16;
  localparam int unsigned STEP_W = 16;
  localparam int unsigned EVT_W = 3;

  localparam logic [THR_W-1:0] LONG_PRESS_RESET = 16'd100;

  typedef enum logic [EVT_W-1:0] {
    EVT_NONE  = 3'd0,
    EVT_CW    = 3'd1,
    EVT_CCW   = 3'd2,
    EVT_CLICK = 3'd3,
    EVT_LONG  = 3'd4
  } event_t;

  // one scan tick
  typedef struct packed {
    logic pin_a;
    logic pin_b;
    logic button_level;
    logic ack_delta;
    logic ack_click;
  } in_item_t;

  // one report per tick
  typedef struct packed {
    logic [EVT_W-1:0]         event_res;
    logic signed [STEP_W-1:0] step_count;
    logic                     clicked;
    logic                     long_pressed;
  } out_item_t;

endpackage

// ===== src/reb_core.sv =====
// scanner state and per-tick decode: quadrature step, hold counter, click / long press
// depends on reb_pkg
`timescale 1ns / 1ps

module reb_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step_en,
  input  reb_pkg::in_item_t          item,
  input  logic [reb_pkg::THR_W-1:0]  long_press_ticks,
  output reb_pkg::out_item_t         res
);

  logic                        prev_a_r, prev_a_nxt;
  logic [reb_pkg::STEP_W-1:0]  net_steps_r, net_steps_nxt;
  logic [reb_pkg::THR_W-1:0]   hold_r, hold_nxt;
  logic                        long_r, long_nxt;
  logic                        click_r, click_nxt;

  logic [reb_pkg::STEP_W-1:0]  steps_mid;
  logic [reb_pkg::THR_W-1:0]   hold_inc;
  logic                        long_mid;
  logic                        click_mid;
  reb_pkg::event_t             evt;

  always_comb begin
    steps_mid = net_steps_r;
    evt       = reb_pkg::EVT_NONE;
    if (item.pin_a != prev_a_r) begin
      if (item.pin_a == item.pin_b) begin
        steps_mid = net_steps_r + reb_pkg::STEP_W'(1);
        evt       = reb_pkg::EVT_CW;
      end else begin
        steps_mid = net_steps_r - reb_pkg::STEP_W'(1);
        evt       = reb_pkg::EVT_CCW;
      end
    end

    // saturating hold counter
    hold_inc  = (hold_r < long_press_ticks) ? hold_r + reb_pkg::THR_W'(1) : hold_r;
    long_mid  = long_r;
    click_mid = click_r;
    if (!item.button_level) begin
      hold_nxt = hold_inc;
      if ((hold_inc >= long_press_ticks) && !long_r) begin
        long_mid = 1'b1;
        evt      = reb_pkg::EVT_LONG;
      end
    end else begin
      // release after a short hold
      if ((hold_r != '0) && (hold_r < long_press_ticks)) begin
        click_mid = 1'b1;
        evt       = reb_pkg::EVT_CLICK;
      end
      hold_nxt = '0;
      long_mid = 1'b0;
    end

    prev_a_nxt    = item.pin_a;
    long_nxt      = long_mid;
    net_steps_nxt = item.ack_delta ? '0 : steps_mid;
    click_nxt     = item.ack_click ? 1'b0 : click_mid;

    res.event_res    = evt;
    res.step_count   = steps_mid;
    res.clicked      = click_mid;
    res.long_pressed = long_mid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_a_r    <= 1'b1;
      net_steps_r <= '0;
      hold_r      <= '0;
      long_r      <= 1'b0;
      click_r     <= 1'b0;
    end else if (step_en) begin
      prev_a_r    <= prev_a_nxt;
      net_steps_r <= net_steps_nxt;
      hold_r      <= hold_nxt;
      long_r      <= long_nxt;
      click_r     <= click_nxt;
    end
  end

`ifndef SYNTHESIS
  a_long_flag : assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && (res.event_res == reb_pkg::EVT_LONG)) |-> res.long_pressed)
    else $error("long press event without long_pressed");

  a_ack_clear : assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && item.ack_delta) |=> (net_steps_r == '0))
    else $error("step count not cleared by acknowledge");

  a_release : assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && item.button_level) |=> ((hold_r == '0) && !long_r))
    else $error("hold state not cleared on release");
`endif

endmodule

// ===== src/rotary_encoder_button_scanner.sv =====
// top level of the rotary encoder / button scanner: handshake, threshold register
// depends on reb_pkg and reb_core
`timescale 1ns / 1ps

// usage
//   input channel: in_valid / in_stall / in_item carries one scan tick (pin a, pin b,
//   active-low button, two acknowledge bits); a transfer happens when in_valid is high
//   and in_stall is low
//   result channel: out_valid / out_stall / out_item gives one report per tick, in
//   tick order: event code, net step count, sticky clicked flag, long-press flag
//   config: cfg_wr_en with cfg_wr_data writes the long-press threshold in ticks;
//   write only while no tick is in flight
//   path: a tick lands in the input register at its transfer, and its report is
//   registered in the output register, raising out_valid, once that register is free
//   throughput: one tick per cycle unless out_stall holds a report; the decode is a
//   single pass between input and output register, and state updates in the same cycle
//   stall: while out_stall holds a report, the input register keeps its tick and
//   in_stall rises only once that register is full; nothing is dropped
//   reset: rst_n low clears both stages, sets the threshold to 100, previous a to 1
//   and the step count, hold counter and flags to 0
module rotary_encoder_button_scanner (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  reb_pkg::in_item_t          in_item,
  output logic                       out_valid,
  input  logic                       out_stall,
  output reb_pkg::out_item_t         out_item,
  input  logic                       cfg_wr_en,
  input  logic [reb_pkg::THR_W-1:0]  cfg_wr_data
);

  // input register stage
  logic               s1_valid_r;
  reb_pkg::in_item_t  s1_item_r;

  // output register stage
  logic               out_valid_r;
  reb_pkg::out_item_t out_item_r;

  logic [reb_pkg::THR_W-1:0] long_press_ticks_r;

  logic               out_free;
  logic               s1_adv;
  logic               in_xfer;
  reb_pkg::out_item_t core_res;

  // output register can take a new report when empty or being drained
  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_xfer  = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  reb_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .step_en          (s1_adv),
    .item             (s1_item_r),
    .long_press_ticks (long_press_ticks_r),
    .res              (core_res)
  );

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r         <= 1'b0;
      out_valid_r        <= 1'b0;
      long_press_ticks_r <= reb_pkg::LONG_PRESS_RESET;
    end else begin
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        long_press_ticks_r <= cfg_wr_data;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r <= in_item;
    end
    if (s1_adv) begin
      out_item_r <= core_res;
    end
  end

endmodule
